[hdl/btnis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btnis_pkg
// Shared types and constants for the B-tree node insert/split block.
// ----------------------------------------------------------------------------
package btnis_pkg;

    localparam int MAX_ORDER = 16;
    localparam int NCELL     = MAX_ORDER + 1;   // key cells plus one child slot
    localparam int IDX_W     = $clog2(NCELL);
    localparam int KEY_W     = 64;
    localparam int NUM_W     = 31;

    localparam logic [NUM_W-1:0] NONE = {NUM_W{1'b1}};

    localparam logic [2:0] FN_CLEAR    = 3'd0;
    localparam logic [2:0] FN_LOADKEY  = 3'd1;
    localparam logic [2:0] FN_LOADLAST = 3'd2;
    localparam logic [2:0] FN_INSERT   = 3'd3;
    localparam logic [2:0] FN_LOOKUP   = 3'd4;
    localparam logic [2:0] FN_READOUT  = 3'd5;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_SPLIT    = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_ENTRY    = 3'd5;
    localparam logic [2:0] ST_REJECT   = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } fsm_t;

    typedef enum logic [1:0] {
        W_SINGLE,
        W_SPLIT,
        W_READ
    } walk_t;

    typedef enum logic [2:0] {
        COP_HOLD,
        COP_LOADKEY,
        COP_LOADLAST,
        COP_INSERT,
        COP_SPLIT
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [KEY_W-1:0]  key;
        logic [NUM_W-1:0]  rec;
        logic [NUM_W-1:0]  lc;
        logic [NUM_W-1:0]  rc;
        logic [IDX_W-1:0]  p;
        logic [IDX_W-1:0]  kc;
        logic [IDX_W-1:0]  cc;
    } cell_cmd_t;

endpackage

[hdl/btree_node_insert_split.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btree_node_insert_split
// One B-tree node held in a row of slot cells: load, insert/split, lookup, read.
// ----------------------------------------------------------------------------
// Flow: an item is accepted in S_IDLE, executed in S_EXEC, and its results are loaded
//   into the output register in S_EMIT. Single-result functions emit one result item;
//   split and read out emit one result item per cycle from the slot row while the output
//   register is free (m_tready back-pressure stalls it). Sequential: next item is
//   accepted only after the last result is loaded into the output register.
// Reset: rst_n asynchronous, clears counts, FSM, output valid; order = 16.
//   Slot contents are undefined until written.
module btree_node_insert_split
    import btnis_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    // config
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [159:0]  s_tdata,  // key[63:0], record[94:64], left_child[125:95],
                                    // right_child[156:126], zero pad
    input  logic [2:0]    s_tuser,  // func[2:0]
    // output stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,  // out_key[63:0], out_record[94:64],
                                    // out_child[125:95], leaf[126], zero pad
    output logic [2:0]    m_tuser,  // status[2:0]
    output logic          m_tlast
);

    // ---------------- configuration ----------------
    logic [4:0] order_reg;
    logic [4:0] ord;
    logic [4:0] half;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {27'd0, order_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= 5'd16;
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
            order_reg <= pwdata[4:0];
    end

    // effective order, clamped
    always_comb
    begin
        if (order_reg < 5'd3)
            ord = 5'd3;
        else if (order_reg > 5'(MAX_ORDER))
            ord = 5'(MAX_ORDER);
        else
            ord = order_reg;
        half = ord >> 1;
    end

    // ---------------- state ----------------
    fsm_t              state_reg, state_next;
    logic [3:0]        key_count_reg, key_count_next;
    logic [4:0]        child_count_reg, child_count_next;
    walk_t             walk_reg, walk_next;
    logic [IDX_W-1:0]  widx_reg, widx_next;
    logic [IDX_W-1:0]  wend_reg, wend_next;
    logic [2:0]        sgl_status_reg, sgl_status_next;
    logic [NUM_W-1:0]  sgl_rec_reg, sgl_rec_next;
    logic [NUM_W-1:0]  sgl_child_reg, sgl_child_next;

    // latched input item
    logic [2:0]        func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [NUM_W-1:0]  rec_reg, lc_reg, rc_reg;

    // output register
    logic              mv_reg, mv_next;
    logic [2:0]        mst_reg, mst_next;
    logic [KEY_W-1:0]  mkey_reg, mkey_next;
    logic [NUM_W-1:0]  mrec_reg, mrec_next;
    logic [NUM_W-1:0]  mch_reg, mch_next;
    logic              mleaf_reg, mleaf_next;
    logic              mlast_reg, mlast_next;

    // ---------------- slot row ----------------
    cell_cmd_t         cmd;
    logic [KEY_W-1:0]  c_key   [NCELL];
    logic [NUM_W-1:0]  c_rec   [NCELL];
    logic [NUM_W-1:0]  c_child [NCELL];
    logic [NCELL-1:0]  c_eq, c_lt;

    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            logic [KEY_W-1:0] lk;
            logic [NUM_W-1:0] lr, lch;
            if (g == 0)
            begin : g_first
                assign lk  = '0;
                assign lr  = '0;
                assign lch = '0;
            end
            else
            begin : g_rest
                assign lk  = c_key[g-1];
                assign lr  = c_rec[g-1];
                assign lch = c_child[g-1];
            end
            btnis_cell u_cell (
                .clk        (clk),
                .idx        (IDX_W'(g)),
                .cmd        (cmd),
                .left_key   (lk),
                .left_rec   (lr),
                .left_child (lch),
                .key        (c_key[g]),
                .rec        (c_rec[g]),
                .child      (c_child[g]),
                .hit_eq     (c_eq[g]),
                .hit_lt     (c_lt[g])
            );
        end
    endgenerate

    // first equal / first greater, scanned as stored
    logic              dup;
    logic [IDX_W-1:0]  fidx, pidx;
    always_comb
    begin
        dup  = |c_eq;
        fidx = '0;
        pidx = IDX_W'(key_count_reg);
        for (int i = NCELL - 1; i >= 0; i--)
        begin
            if (c_eq[i])
                fidx = IDX_W'(i);
            if (c_lt[i])
                pidx = IDX_W'(i);
        end
    end

    logic leaf;
    assign leaf = (child_count_reg == '0) || (c_child[0] == NONE);

    // ---------------- control ----------------
    logic             out_free;
    logic [IDX_W-1:0] kc_x;
    logic [NUM_W-1:0] ch_p, ch_w;

    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign kc_x     = IDX_W'(key_count_reg);
    assign ch_p     = (pidx < IDX_W'(child_count_reg)) ? c_child[pidx] : NONE;
    assign ch_w     = (widx_reg < IDX_W'(child_count_reg)) ? c_child[widx_reg] : NONE;

    always_comb
    begin
        state_next       = state_reg;
        key_count_next   = key_count_reg;
        child_count_next = child_count_reg;
        walk_next        = walk_reg;
        widx_next        = widx_reg;
        wend_next        = wend_reg;
        sgl_status_next  = sgl_status_reg;
        sgl_rec_next     = sgl_rec_reg;
        sgl_child_next   = sgl_child_reg;
        mv_next          = mv_reg && !m_tready;
        mst_next         = mst_reg;
        mkey_next        = mkey_reg;
        mrec_next        = mrec_reg;
        mch_next         = mch_reg;
        mleaf_next       = mleaf_reg;
        mlast_next       = mlast_reg;

        cmd.op  = COP_HOLD;
        cmd.key = key_reg;
        cmd.rec = rec_reg;
        cmd.lc  = lc_reg;
        cmd.rc  = rc_reg;
        cmd.p   = pidx;
        cmd.kc  = kc_x;
        cmd.cc  = IDX_W'(child_count_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next      = S_EMIT;
                walk_next       = W_SINGLE;
                widx_next       = '0;
                wend_next       = '0;
                sgl_status_next = ST_DONE;
                sgl_rec_next    = NONE;
                sgl_child_next  = NONE;
                unique case (func_reg)
                    FN_CLEAR:
                    begin
                        key_count_next   = '0;
                        child_count_next = '0;
                    end
                    FN_LOADKEY:
                    begin
                        if ({1'b0, key_count_reg} >= ord - 5'd1)
                            sgl_status_next = ST_REJECT;
                        else
                        begin
                            cmd.op           = COP_LOADKEY;
                            key_count_next   = key_count_reg + 4'd1;
                            child_count_next = {1'b0, key_count_reg} + 5'd1;
                        end
                    end
                    FN_LOADLAST:
                    begin
                        cmd.op           = COP_LOADLAST;
                        child_count_next = {1'b0, key_count_reg} + 5'd1;
                    end
                    FN_INSERT:
                    begin
                        if (dup)
                            sgl_status_next = ST_DUP;
                        else if ({1'b0, key_count_reg} < ord - 5'd1)
                        begin
                            cmd.op           = COP_INSERT;
                            key_count_next   = key_count_reg + 4'd1;
                            child_count_next = (child_count_reg == '0) ? 5'd2
                                                : child_count_reg + 5'd1;
                        end
                        else
                        begin
                            cmd.op           = COP_SPLIT;
                            key_count_next   = half[3:0];
                            child_count_next = half + 5'd1;
                            walk_next        = W_SPLIT;
                            widx_next        = IDX_W'(half);
                            wend_next        = kc_x;
                        end
                    end
                    FN_LOOKUP:
                    begin
                        if (dup)
                        begin
                            sgl_status_next = ST_FOUND;
                            sgl_rec_next    = c_rec[fidx];
                        end
                        else
                        begin
                            sgl_status_next = ST_NOTFOUND;
                            sgl_child_next  = ch_p;
                        end
                    end
                    FN_READOUT:
                    begin
                        walk_next = W_READ;
                        wend_next = kc_x;
                    end
                    default:
                        sgl_status_next = ST_REJECT;
                endcase
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    mv_next    = 1'b1;
                    mleaf_next = leaf;
                    mkey_next  = '0;
                    mrec_next  = NONE;
                    mlast_next = (widx_reg == wend_reg);
                    case (walk_reg)
                        W_SPLIT:
                        begin
                            mst_next  = ST_SPLIT;
                            mkey_next = c_key[widx_reg];
                            mrec_next = c_rec[widx_reg];
                            mch_next  = c_child[widx_reg + IDX_W'(1)];
                        end
                        W_READ:
                        begin
                            mch_next = ch_w;
                            if (widx_reg == wend_reg)
                                mst_next = ST_DONE;
                            else
                            begin
                                mst_next  = ST_ENTRY;
                                mkey_next = c_key[widx_reg];
                                mrec_next = c_rec[widx_reg];
                            end
                        end
                        default:
                        begin
                            mst_next  = sgl_status_reg;
                            mrec_next = sgl_rec_reg;
                            mch_next  = sgl_child_reg;
                        end
                    endcase
                    widx_next = widx_reg + IDX_W'(1);
                    if (widx_reg == wend_reg)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            key_count_reg   <= '0;
            child_count_reg <= '0;
            mv_reg          <= 1'b0;
            walk_reg        <= W_SINGLE;
            widx_reg        <= '0;
            wend_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            key_count_reg   <= key_count_next;
            child_count_reg <= child_count_next;
            mv_reg          <= mv_next;
            walk_reg        <= walk_next;
            widx_reg        <= widx_next;
            wend_reg        <= wend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sgl_status_reg <= sgl_status_next;
        sgl_rec_reg    <= sgl_rec_next;
        sgl_child_reg  <= sgl_child_next;
        mst_reg        <= mst_next;
        mkey_reg       <= mkey_next;
        mrec_reg       <= mrec_next;
        mch_reg        <= mch_next;
        mleaf_reg      <= mleaf_next;
        mlast_reg      <= mlast_next;
        if (s_tvalid && s_tready)
        begin
            func_reg <= s_tuser;
            key_reg  <= s_tdata[63:0];
            rec_reg  <= s_tdata[94:64];
            lc_reg   <= s_tdata[125:95];
            rc_reg   <= s_tdata[156:126];
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = mst_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {1'b0, mleaf_reg, mch_reg, mrec_reg, mkey_reg};

`ifndef NO_ASSERTIONS
    // one item in flight: no accept right after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while busy");

    // child count never runs more than one past the key count
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, child_count_reg} <= {2'b0, key_count_reg} + 6'd1)
        else $error("child count beyond key count plus one");

    // the walk index never runs past the end of its walk
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (widx_reg <= wend_reg))
        else $error("walk index past its end");

    // back to idle only after the final result was loaded
    a_last_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == S_EMIT && state_reg == S_IDLE) |-> (m_tvalid && m_tlast))
        else $error("walk ended without final result");
`endif

endmodule

[hdl/btnis_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btnis_cell
// One slot of the node: key, record and child, shifting from its left neighbor.
// ----------------------------------------------------------------------------
module btnis_cell
    import btnis_pkg::*;
(
    input  logic              clk,
    input  logic [IDX_W-1:0]  idx,
    input  cell_cmd_t         cmd,
    input  logic [KEY_W-1:0]  left_key,
    input  logic [NUM_W-1:0]  left_rec,
    input  logic [NUM_W-1:0]  left_child,
    output logic [KEY_W-1:0]  key,
    output logic [NUM_W-1:0]  rec,
    output logic [NUM_W-1:0]  child,
    output logic              hit_eq,
    output logic              hit_lt
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [NUM_W-1:0] rec_reg, rec_next;
    logic [NUM_W-1:0] child_reg, child_next;
    logic [IDX_W:0]   idx_x, p1, kc1, cc_x, pos;
    logic [NUM_W-1:0] own_at, left_at;

    assign key    = key_reg;
    assign rec    = rec_reg;
    assign child  = child_reg;
    assign hit_eq = (idx < cmd.kc) && (key_reg == cmd.key);
    assign hit_lt = (idx < cmd.kc) && (cmd.key < key_reg);

    always_comb
    begin
        idx_x      = {1'b0, idx};
        p1         = {1'b0, cmd.p} + 1'b1;
        kc1        = {1'b0, cmd.kc} + 1'b1;
        cc_x       = {1'b0, cmd.cc};
        pos        = (p1 > cc_x) ? cc_x : p1;
        own_at     = (idx < cmd.cc) ? child_reg : NONE;
        left_at    = (idx_x <= cc_x) ? left_child : NONE;
        key_next   = key_reg;
        rec_next   = rec_reg;
        child_next = child_reg;
        case (cmd.op)
            COP_LOADKEY:
            begin
                if (idx == cmd.kc)
                begin
                    key_next   = cmd.key;
                    rec_next   = cmd.rec;
                    child_next = cmd.lc;
                end
            end
            COP_LOADLAST:
            begin
                if (idx == cmd.kc)
                    child_next = cmd.lc;
            end
            COP_INSERT, COP_SPLIT:
            begin
                if (idx == cmd.p)
                begin
                    key_next = cmd.key;
                    rec_next = cmd.rec;
                end
                else if (idx > cmd.p && idx <= cmd.kc)
                begin
                    key_next = left_key;
                    rec_next = left_rec;
                end
                if (cmd.op == COP_INSERT)
                begin
                    if (cmd.cc == '0)
                    begin
                        if (idx_x == '0)
                            child_next = cmd.lc;
                        else if (idx_x == 1)
                            child_next = cmd.rc;
                    end
                    else if (idx_x == pos)
                        child_next = cmd.rc;
                    else if (idx_x > pos && idx_x <= cc_x)
                        child_next = left_child;
                end
                else
                begin
                    if (idx < cmd.p)
                        child_next = own_at;
                    else if (idx == cmd.p)
                        child_next = cmd.lc;
                    else if (idx_x == p1)
                        child_next = cmd.rc;
                    else if (idx_x <= kc1)
                        child_next = left_at;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        rec_reg   <= rec_next;
        child_reg <= child_next;
    end

endmodule
